// ===== rtl/core/hbpd_pkg.sv =====
// ----------------------------------------------------------------------------
// hbpd_pkg
// Shared widths, limits, reset values and types of the heartbeat pulse
// detector.
// ----------------------------------------------------------------------------
package hbpd_pkg;

    // time and rate fields
    localparam int ELAPSED_W    = 14;
    localparam int ELAPSED_MAX  = (2 ** ELAPSED_W) - 1;
    localparam int INTERVAL_W   = 13;
    localparam int INTERVAL_MAX = (2 ** INTERVAL_W) - 1;
    localparam int BPM_W        = 10;
    localparam int BPM_MAX      = (2 ** BPM_W) - 1;
    localparam int THR_OUT_W    = 10;
    localparam int MS_PER_MIN   = 60000;

    // register widths
    localparam int PERIOD_W  = 4;
    localparam int REFR_W    = 12;
    localparam int TIMEOUT_W = 13;
    localparam int BASE_W    = 10;
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = 13;

    typedef enum logic [CFG_AW-1:0] {
        CFG_SAMPLE_PERIOD = 2'd0,
        CFG_REFRACTORY    = 2'd1,
        CFG_TIMEOUT       = 2'd2,
        CFG_BASELINE      = 2'd3
    } t_cfg_idx;

    localparam logic [PERIOD_W-1:0]  PERIOD_RST  = 4'd2;
    localparam logic [REFR_W-1:0]    REFR_RST    = 12'd250;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 13'd2500;
    localparam logic [BASE_W-1:0]    BASE_RST    = 10'd512;

    localparam int LAST_INTERVAL_INIT = 600;
    localparam logic [INTERVAL_W-1:0] LAST_INTERVAL_RST = INTERVAL_W'(LAST_INTERVAL_INIT);

    // x/5 as (x * RECIP5) >> RECIP5_SHIFT, exact for x below 2^14
    localparam int RECIP_W      = 16;
    localparam int RECIP5       = 52429;
    localparam int RECIP5_SHIFT = 18;
    localparam logic [INTERVAL_W-1:0] DICROTIC_RST = INTERVAL_W'((LAST_INTERVAL_INIT / 5) * 3);

    typedef struct packed {
        logic             done;
        logic [BPM_W-1:0] bpm;
    } t_div_res;

endpackage

// ===== rtl/core/heartbeat_pulse_detector.sv =====
// ----------------------------------------------------------------------------
// heartbeat_pulse_detector
// Pulse-sensor beat detector and BPM meter, one result beat per sample.
// ----------------------------------------------------------------------------
// One sample is taken at a time. A beat that updates BPM also passes
// through the bit-serial divider, which the BPM saturation check can cut
// short; the second beat after start-up or timeout first seeds the interval
// history memory one entry per cycle. The next sample is taken while the
// previous result still waits at the output register.
// ----------------------------------------------------------------------------
module heartbeat_pulse_detector #(
    parameter int HISTORY_DEPTH = 10,
    parameter int SAMPLE_BITS   = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hbpd_pkg::CFG_AW-1:0]       i_cfg_idx,
    input  logic [hbpd_pkg::CFG_DW-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [SAMPLE_BITS-1:0]            i_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_beat_found,
    output logic [hbpd_pkg::BPM_W-1:0]        o_bpm,
    output logic [hbpd_pkg::INTERVAL_W-1:0]   o_interval_ms,
    output logic                              o_pulse_high,
    output logic [hbpd_pkg::THR_OUT_W-1:0]    o_level_threshold
);

    import hbpd_pkg::*;

    localparam int LVL_W    = SAMPLE_BITS;
    localparam int HIST_AW  = $clog2(HISTORY_DEPTH);
    localparam int SUM_W    = INTERVAL_W + $clog2(HISTORY_DEPTH + 1);
    localparam int DIVIDEND = MS_PER_MIN * HISTORY_DEPTH;
    localparam int MUL_W    = INTERVAL_W + RECIP_W;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EVAL    = 6'b000010,
        S_SEED    = 6'b000100,
        S_DIVGO   = 6'b001000,
        S_DIVWAIT = 6'b010000,
        S_FIN     = 6'b100000
    } t_state;

    t_state                 r_state;

    // configuration
    logic [PERIOD_W-1:0]    r_period;
    logic [REFR_W-1:0]      r_refr;
    logic [TIMEOUT_W-1:0]   r_timeout;
    logic [BASE_W-1:0]      r_base;

    // detector state
    logic [LVL_W-1:0]       r_sample;
    logic [ELAPSED_W-1:0]   r_elapsed;
    logic [INTERVAL_W-1:0]  r_last;
    logic [INTERVAL_W-1:0]  r_dicrotic;
    logic [LVL_W-1:0]       r_peak;
    logic [LVL_W-1:0]       r_trough;
    logic [LVL_W-1:0]       r_thr;
    logic                   r_pulse;
    logic                   r_first;
    logic                   r_second;
    logic                   r_found;
    logic [BPM_W-1:0]       r_bpm;
    logic [SUM_W-1:0]       r_sum;
    logic [HIST_AW-1:0]     r_ptr;
    logic [HIST_AW-1:0]     r_seed_cnt;

    // output register
    logic                   r_out_valid;
    logic                   r_o_found;
    logic [BPM_W-1:0]       r_o_bpm;
    logic [INTERVAL_W-1:0]  r_o_interval;
    logic                   r_o_pulse;
    logic [THR_OUT_W-1:0]   r_o_thr;

    // evaluation
    logic [ELAPSED_W:0]     w_n_raw;
    logic [ELAPSED_W-1:0]   w_n;
    logic [INTERVAL_W-1:0]  w_last_new;
    logic                   w_past;
    logic                   w_below;
    logic                   w_above;
    logic                   w_beat;
    logic                   w_fall;
    logic                   w_tmo;
    logic [LVL_W-1:0]       w_trough_a;
    logic [LVL_W-1:0]       w_peak_a;
    logic signed [LVL_W+1:0] w_amp;
    logic signed [LVL_W+1:0] w_half;
    logic signed [LVL_W+1:0] w_th_raw;
    logic [LVL_W-1:0]       w_th;
    logic [LVL_W-1:0]       w_base_lvl;
    logic [MUL_W-1:0]       w_prod;
    logic [INTERVAL_W-1:0]  w_fifth;
    logic [HIST_AW-1:0]     w_ptr_nxt;

    // history memory and divider
    logic                   w_mem_we;
    logic [HIST_AW-1:0]     w_mem_waddr;
    logic [INTERVAL_W-1:0]  w_mem_wdata;
    logic [INTERVAL_W-1:0]  w_mem_rdata;
    t_div_res               w_div;

    hbpd_hist_mem #(
        .DEPTH  (HISTORY_DEPTH),
        .DATA_W (INTERVAL_W)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (r_ptr),
        .o_rdata (w_mem_rdata)
    );

    hbpd_bpm_div #(
        .SUM_W    (SUM_W),
        .DIVIDEND (DIVIDEND)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIVGO),
        .i_sum   (r_sum),
        .o_res   (w_div)
    );

    always_comb begin
        w_n_raw    = {1'b0, r_elapsed} + (ELAPSED_W + 1)'(r_period);
        w_n        = (w_n_raw > (ELAPSED_W + 1)'(ELAPSED_MAX)) ? ELAPSED_W'(ELAPSED_MAX)
                                                                : w_n_raw[ELAPSED_W-1:0];
        w_last_new = (w_n > ELAPSED_W'(INTERVAL_MAX)) ? INTERVAL_W'(INTERVAL_MAX)
                                                      : w_n[INTERVAL_W-1:0];
        w_past     = w_n > ELAPSED_W'(r_dicrotic);
        w_below    = r_sample < r_thr;
        w_above    = r_sample > r_thr;

        w_trough_a = (w_below && w_past && (r_sample < r_trough)) ? r_sample : r_trough;
        w_peak_a   = (w_above && (r_sample > r_peak)) ? r_sample : r_peak;

        w_beat = (w_n > ELAPSED_W'(r_refr)) && w_above && !r_pulse && w_past;
        // a beat leaves the sample above threshold, so no fall on the same step
        w_fall = w_below && r_pulse;
        w_tmo  = w_n > ELAPSED_W'(r_timeout);

        // trough + (peak - trough)/2, halving towards zero
        w_amp    = $signed({2'b00, w_peak_a}) - $signed({2'b00, w_trough_a});
        w_half   = (w_amp + $signed((LVL_W + 2)'(w_amp[LVL_W+1]))) >>> 1;
        w_th_raw = w_half + $signed({2'b00, w_trough_a});
        if (w_th_raw < 0) begin
            w_th = '0;
        end else if (w_th_raw > $signed({2'b00, {LVL_W{1'b1}}})) begin
            w_th = {LVL_W{1'b1}};
        end else begin
            w_th = w_th_raw[LVL_W-1:0];
        end

        w_base_lvl = LVL_W'(r_base);

        // 3/5 of the last interval, refreshed every cycle from r_last
        w_prod  = MUL_W'(r_last) * MUL_W'(RECIP5);
        w_fifth = INTERVAL_W'(w_prod >> RECIP5_SHIFT);

        w_ptr_nxt = (r_ptr == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : r_ptr + 1'b1;

        w_mem_we    = (r_state == S_SEED)
                   || ((r_state == S_EVAL) && w_beat && !r_first && !r_second);
        w_mem_waddr = (r_state == S_SEED) ? r_seed_cnt : r_ptr;
        w_mem_wdata = (r_state == S_SEED) ? r_last : w_last_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= PERIOD_RST;
            r_refr      <= REFR_RST;
            r_timeout   <= TIMEOUT_RST;
            r_base      <= BASE_RST;
            r_elapsed   <= '0;
            r_last      <= LAST_INTERVAL_RST;
            r_dicrotic  <= DICROTIC_RST;
            r_peak      <= LVL_W'(BASE_RST);
            r_trough    <= LVL_W'(BASE_RST);
            r_thr       <= LVL_W'(BASE_RST);
            r_pulse     <= 1'b0;
            r_first     <= 1'b1;
            r_second    <= 1'b1;
            r_found     <= 1'b0;
            r_bpm       <= '0;
            r_sum       <= '0;
            r_ptr       <= '0;
            r_seed_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_dicrotic <= (w_fifth << 1) + w_fifth;

            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_SAMPLE_PERIOD: r_period  <= i_cfg_data[PERIOD_W-1:0];
                    CFG_REFRACTORY:    r_refr    <= i_cfg_data[REFR_W-1:0];
                    CFG_TIMEOUT:       r_timeout <= i_cfg_data[TIMEOUT_W-1:0];
                    CFG_BASELINE:      r_base    <= i_cfg_data[BASE_W-1:0];
                endcase
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EVAL;
                    end
                end

                S_EVAL: begin
                    r_elapsed <= w_n;
                    r_trough  <= w_trough_a;
                    r_peak    <= w_peak_a;
                    r_found   <= 1'b0;
                    r_state   <= S_FIN;
                    if (w_beat) begin
                        r_pulse   <= 1'b1;
                        r_last    <= w_last_new;
                        r_elapsed <= '0;
                        if (r_first) begin
                            r_first <= 1'b0;
                        end else begin
                            r_found <= 1'b1;
                            if (r_second) begin
                                r_second   <= 1'b0;
                                r_sum      <= '0;
                                r_seed_cnt <= '0;
                                r_state    <= S_SEED;
                            end else begin
                                // running sum: drop the oldest entry, add the new one
                                r_sum   <= r_sum - SUM_W'(w_mem_rdata) + SUM_W'(w_last_new);
                                r_ptr   <= w_ptr_nxt;
                                r_state <= S_DIVGO;
                            end
                        end
                    end
                    if (w_fall) begin
                        r_pulse  <= 1'b0;
                        r_thr    <= w_th;
                        r_peak   <= w_th;
                        r_trough <= w_th;
                    end
                    // first beat ends the step before the timeout check
                    if (w_tmo && !(w_beat && r_first)) begin
                        r_thr     <= w_base_lvl;
                        r_peak    <= w_base_lvl;
                        r_trough  <= w_base_lvl;
                        r_elapsed <= '0;
                        r_first   <= 1'b1;
                        r_second  <= 1'b1;
                    end
                end

                S_SEED: begin
                    r_sum      <= r_sum + SUM_W'(r_last);
                    r_seed_cnt <= r_seed_cnt + 1'b1;
                    if (r_seed_cnt == HIST_AW'(HISTORY_DEPTH - 1)) begin
                        r_state <= S_DIVGO;
                    end
                end

                S_DIVGO: begin
                    r_state <= S_DIVWAIT;
                end

                S_DIVWAIT: begin
                    if (w_div.done) begin
                        r_bpm   <= w_div.bpm;
                        r_state <= S_FIN;
                    end
                end

                S_FIN: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_sample <= i_sample;
        end
        if ((r_state == S_FIN) && (!r_out_valid || !i_out_stall)) begin
            r_o_found    <= r_found;
            r_o_bpm      <= r_bpm;
            r_o_interval <= r_last;
            r_o_pulse    <= r_pulse;
            r_o_thr      <= THR_OUT_W'(r_thr);
        end
    end

    assign o_in_stall        = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid       = r_out_valid;
    assign o_beat_found      = r_o_found;
    assign o_bpm             = r_o_bpm;
    assign o_interval_ms     = r_o_interval;
    assign o_pulse_high      = r_o_pulse;
    assign o_level_threshold = r_o_thr;

endmodule

// ===== rtl/core/hbpd_hist_mem.sv =====
// ----------------------------------------------------------------------------
// hbpd_hist_mem
// Interval history store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hbpd_hist_mem #(
    parameter int DEPTH  = 10,
    parameter int DATA_W = 13
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/hbpd_bpm_div.sv =====
// ----------------------------------------------------------------------------
// hbpd_bpm_div
// Iterative restoring divider for BPM = DIVIDEND / sum, saturated at the
// BPM limit. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module hbpd_bpm_div #(
    parameter int SUM_W    = 17,
    parameter int DIVIDEND = 600000
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [SUM_W-1:0]          i_sum,
    output hbpd_pkg::t_div_res        o_res
);

    import hbpd_pkg::*;

    localparam int W     = SUM_W + BPM_W;
    localparam int CNT_W = $clog2(BPM_W);

    logic [W-1:0]       r_rem;
    logic [W-1:0]       r_dsh;
    logic [BPM_W-1:0]   r_quo;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic               w_sat;
    logic               w_fit;

    // quotient of 1024 or more cannot fit: clamp straight away
    assign w_sat = (i_sum == '0) || (W'(DIVIDEND) >= {i_sum, {BPM_W{1'b0}}});
    assign w_fit = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo <= '0;
                if (w_sat) begin
                    r_quo  <= BPM_W'(BPM_MAX);
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= W'(DIVIDEND);
                    r_dsh  <= W'(i_sum) << (BPM_W - 1);
                    r_cnt  <= CNT_W'(BPM_W - 1);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (w_fit) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_quo <= {r_quo[BPM_W-2:0], w_fit};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.bpm  = r_quo;

endmodule

// ===== rtl/core/hbpd_checker.sv =====
// ----------------------------------------------------------------------------
// hbpd_checker
// Port-level checks of the heartbeat pulse detector, bound to the top level.
// ----------------------------------------------------------------------------
module hbpd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic                              o_beat_found,
    input logic [hbpd_pkg::BPM_W-1:0]        o_bpm,
    input logic [hbpd_pkg::INTERVAL_W-1:0]   o_interval_ms,
    input logic                              o_pulse_high
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // one sample in flight: the cycle after acceptance the input is stalled
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second sample accepted while one is being processed");

    // a BPM update only comes with the pulse flag raised
    a_beat_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_beat_found) |-> o_pulse_high)
        else $error("beat reported without pulse flag");

    // interval history never exceeds the dividend, so a fresh BPM is non-zero
    a_beat_bpm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_beat_found) |-> ((o_bpm != '0) && (o_interval_ms != '0)))
        else $error("beat reported with zero BPM or interval");

endmodule

bind heartbeat_pulse_detector hbpd_checker u_hbpd_checker (.*);
